### src/assert_macros.svh
// assertion macros used by ccd_core of the coin change dispenser
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

### src/ccd_pkg.sv
// shared types, constants and coin tables of the coin change dispenser
// used by ccd_core and coin_change_dispenser; no dependencies
package ccd_pkg;

	localparam int NUM_DENOMS  = 9;
	localparam int COUNT_WIDTH = 16;

	localparam int CMD_W       = 2;
	localparam int DENOM_W     = 4;
	localparam int CNT_W       = 16;
	localparam int PRICE_W     = 16;
	localparam int INS_W       = 7;
	localparam int RET_W       = 16;
	localparam int TOTAL_W     = 17;
	localparam int VALUE_W     = 9;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 26;
	localparam int STATUS_W    = 2;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 168;

	localparam logic [INS_W-1:0] INSERT_MAX = INS_W'(99);
	localparam logic [RET_W-1:0] RET_MAX    = {RET_W{1'b1}};

	// command codes on s_tuser
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PAY    = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_EXACT  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_SHORT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_INSUFF = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CMP,
		ST_RD,
		ST_QEST,
		ST_NSEL,
		ST_UPD,
		ST_DONE
	} state_t;

	// memory access request from the core, same address for both stores
	typedef struct packed {
		logic               rd_en;
		logic               inv_we;
		logic               ins_we;
		logic [DENOM_W-1:0] addr;
	} mem_ctl_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]                unreturned;
		logic [NUM_DENOMS-1:0][RET_W-1:0] ret;
		logic [STATUS_W-1:0]               status;
	} result_t;

	// coin value in grosze
	function automatic logic [VALUE_W-1:0] coin_value(input logic [DENOM_W-1:0] idx);
		logic [VALUE_W-1:0] v;
		case (idx)
			4'd0:    v = 9'd1;
			4'd1:    v = 9'd2;
			4'd2:    v = 9'd5;
			4'd3:    v = 9'd10;
			4'd4:    v = 9'd20;
			4'd5:    v = 9'd50;
			4'd6:    v = 9'd100;
			4'd7:    v = 9'd200;
			4'd8:    v = 9'd500;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// floor(2^26 / value), quotient estimate is exact or one low
	function automatic logic [RECIP_W-1:0] coin_recip(input logic [DENOM_W-1:0] idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			4'd0:    r = 27'd67108864;
			4'd1:    r = 27'd33554432;
			4'd2:    r = 27'd13421772;
			4'd3:    r = 27'd6710886;
			4'd4:    r = 27'd3355443;
			4'd5:    r = 27'd1342177;
			4'd6:    r = 27'd671088;
			4'd7:    r = 27'd335544;
			4'd8:    r = 27'd134217;
			default: r = 27'd0;
		endcase
		return r;
	endfunction

endpackage

### src/ccd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ccd_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/ccd_core.sv
// command sequencer and payout datapath of the coin change dispenser
// depends on ccd_pkg and assert_macros.svh; stock and inserted counts live in rams outside
`include "assert_macros.svh"

module ccd_core #(
	parameter int COUNT_WIDTH = ccd_pkg::COUNT_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ccd_pkg::CMD_W-1:0]       command,
	input  logic [ccd_pkg::DENOM_W-1:0]     denomination,
	input  logic [ccd_pkg::CNT_W-1:0]       coin_count,
	input  logic [ccd_pkg::PRICE_W-1:0]     price,
	output ccd_pkg::mem_ctl_t               mem_ctl,
	output logic [COUNT_WIDTH-1:0]          inv_wdata,
	input  logic [COUNT_WIDTH-1:0]          inv_rdata,
	output logic [ccd_pkg::INS_W-1:0]       ins_wdata,
	input  logic [ccd_pkg::INS_W-1:0]       ins_rdata,
	output logic                            res_valid,
	input  logic                            res_ready,
	output ccd_pkg::result_t                res
);

	localparam int TW     = ccd_pkg::TOTAL_W;
	localparam int SW     = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;
	localparam int PROD_W = TW + ccd_pkg::RECIP_W;
	localparam int QV_W   = TW + ccd_pkg::VALUE_W;
	localparam int ND     = ccd_pkg::NUM_DENOMS;
	localparam int DW     = ccd_pkg::DENOM_W;
	localparam int RW     = ccd_pkg::RET_W;

	ccd_pkg::state_t state_q, state_d;

	logic [DW-1:0]                 idx_q;
	logic [TW-1:0]                 total_q;
	logic [TW-1:0]                 change_q;
	logic [ccd_pkg::PRICE_W-1:0]   price_q;
	logic [PROD_W-1:0]             prod_q;
	logic [TW-1:0]                 qest_q;
	logic [TW-1:0]                 qv_q;
	logic [COUNT_WIDTH-1:0]        stock_q;
	logic [RW-1:0]                 n_q;
	logic [ND-1:0][RW-1:0]         ret_q;
	logic                          short_q;
	logic [ND-1:0]                 inv_vld_q;
	logic [ND-1:0]                 ins_vld_q;
	logic                          inv_ok_s1;
	logic                          ins_ok_s1;
	logic                          acc_en_s1;
	logic [DW-1:0]                 sidx_s1;

	logic                          den_ok;
	logic [ccd_pkg::VALUE_W-1:0]   cur_value;
	logic [COUNT_WIDTH-1:0]        inv_rd;
	logic [ccd_pkg::INS_W-1:0]     ins_rd;
	logic [RW-1:0]                 sum_term;
	logic [SW-1:0]                 cmax_w;
	logic [SW:0]                   stock_sum;
	logic [COUNT_WIDTH-1:0]        stock_sat;
	logic [TW-1:0]                 qest;
	logic [QV_W-1:0]               qv_full;
	logic [TW-1:0]                 rem_w;
	logic [TW-1:0]                 q_fix;
	logic [SW-1:0]                 q_w;
	logic [SW-1:0]                 stock_w;
	logic [SW-1:0]                 n_w;
	logic [QV_W-1:0]               nv_full;
	logic [COUNT_WIDTH-1:0]        load_sat;
	logic [COUNT_WIDTH-1:0]        upd_data;

	assign den_ok    = denomination < DW'(ND);
	assign cur_value = ccd_pkg::coin_value(idx_q);

	// never-written entries read as zero
	assign inv_rd = inv_ok_s1 ? inv_rdata : '0;
	assign ins_rd = ins_ok_s1 ? ins_rdata : '0;

	assign sum_term = RW'(ins_rd) * RW'(ccd_pkg::coin_value(sidx_s1));

	assign cmax_w    = SW'({COUNT_WIDTH{1'b1}});
	assign stock_sum = (SW+1)'(inv_rd) + (SW+1)'(ins_rd);
	assign stock_sat = (stock_sum > (SW+1)'(cmax_w)) ? {COUNT_WIDTH{1'b1}}
		: stock_sum[COUNT_WIDTH-1:0];

	// reciprocal estimate of change / value, at most one low
	assign qest    = prod_q[ccd_pkg::RECIP_SHIFT +: TW];
	assign qv_full = QV_W'(qest) * QV_W'(cur_value);
	assign rem_w   = change_q - qv_q;
	assign q_fix   = qest_q + TW'(rem_w >= TW'(cur_value));

	always_comb begin
		q_w     = SW'(q_fix);
		stock_w = SW'(stock_q);
		n_w     = (q_w < stock_w) ? q_w : stock_w;
		if (n_w > SW'(ccd_pkg::RET_MAX)) begin
			n_w = SW'(ccd_pkg::RET_MAX);
		end
	end

	assign nv_full  = QV_W'(n_q) * QV_W'(cur_value);
	assign load_sat = (SW'(coin_count) > cmax_w) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(coin_count);
	assign upd_data = stock_q - COUNT_WIDTH'(n_q);

	assign ins_wdata = (coin_count > ccd_pkg::CNT_W'(ccd_pkg::INSERT_MAX)) ? ccd_pkg::INSERT_MAX
		: coin_count[ccd_pkg::INS_W-1:0];
	assign inv_wdata = (state_q == ccd_pkg::ST_UPD) ? upd_data : load_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_ctl   = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ccd_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				mem_ctl.addr = denomination;
				if (in_valid) begin
					case (command)
						ccd_pkg::CMD_LOAD:   mem_ctl.inv_we = den_ok;
						ccd_pkg::CMD_INSERT: mem_ctl.ins_we = den_ok;
						ccd_pkg::CMD_PAY:    state_d = ccd_pkg::ST_SUM;
						default:             state_d = ccd_pkg::ST_IDLE;
					endcase
				end
			end
			ccd_pkg::ST_SUM: begin
				mem_ctl.addr  = idx_q;
				mem_ctl.rd_en = idx_q < DW'(ND);
				if (idx_q == DW'(ND)) begin
					state_d = ccd_pkg::ST_CMP;
				end
			end
			ccd_pkg::ST_CMP: begin
				state_d = (total_q < TW'(price_q)) ? ccd_pkg::ST_DONE : ccd_pkg::ST_RD;
			end
			ccd_pkg::ST_RD: begin
				mem_ctl.addr  = idx_q;
				mem_ctl.rd_en = 1'b1;
				state_d       = ccd_pkg::ST_QEST;
			end
			ccd_pkg::ST_QEST: begin
				state_d = ccd_pkg::ST_NSEL;
			end
			ccd_pkg::ST_NSEL: begin
				state_d = ccd_pkg::ST_UPD;
			end
			ccd_pkg::ST_UPD: begin
				mem_ctl.addr   = idx_q;
				mem_ctl.inv_we = 1'b1;
				state_d        = (idx_q == '0) ? ccd_pkg::ST_DONE : ccd_pkg::ST_RD;
			end
			ccd_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ccd_pkg::ST_IDLE;
				end
			end
			default: state_d = ccd_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			short_q   <= 1'b0;
			inv_vld_q <= '0;
			ins_vld_q <= '0;
			inv_ok_s1 <= 1'b0;
			ins_ok_s1 <= 1'b0;
			acc_en_s1 <= 1'b0;
			sidx_s1   <= '0;
		end else begin
			acc_en_s1 <= (state_q == ccd_pkg::ST_SUM) && (idx_q < DW'(ND));
			sidx_s1   <= idx_q;
			if (mem_ctl.rd_en) begin
				inv_ok_s1 <= inv_vld_q[mem_ctl.addr];
				ins_ok_s1 <= ins_vld_q[mem_ctl.addr];
			end
			if (mem_ctl.inv_we) begin
				inv_vld_q[mem_ctl.addr] <= 1'b1;
			end
			if (mem_ctl.ins_we) begin
				ins_vld_q[mem_ctl.addr] <= 1'b1;
			end
			case (state_q)
				ccd_pkg::ST_IDLE: begin
					idx_q <= '0;
				end
				ccd_pkg::ST_SUM: begin
					idx_q <= idx_q + DW'(1);
				end
				ccd_pkg::ST_CMP: begin
					idx_q   <= DW'(ND - 1);
					short_q <= total_q < TW'(price_q);
				end
				ccd_pkg::ST_UPD: begin
					if (idx_q == '0) begin
						ins_vld_q <= '0;
					end else begin
						idx_q <= idx_q - DW'(1);
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ccd_pkg::ST_IDLE: begin
				total_q <= '0;
				price_q <= price;
			end
			ccd_pkg::ST_SUM: begin
				if (acc_en_s1) begin
					total_q <= total_q + TW'(sum_term);
				end
			end
			ccd_pkg::ST_CMP: begin
				change_q <= total_q - TW'(price_q);
			end
			ccd_pkg::ST_RD: begin
				prod_q <= PROD_W'(change_q) * PROD_W'(ccd_pkg::coin_recip(idx_q));
			end
			ccd_pkg::ST_QEST: begin
				qest_q  <= qest;
				qv_q    <= qv_full[TW-1:0];
				stock_q <= stock_sat;
			end
			ccd_pkg::ST_NSEL: begin
				n_q <= n_w[RW-1:0];
			end
			ccd_pkg::ST_UPD: begin
				change_q     <= change_q - nv_full[TW-1:0];
				ret_q[idx_q] <= n_q;
			end
			default: total_q <= total_q;
		endcase
	end

	always_comb begin
		if (short_q) begin
			res.status     = ccd_pkg::STAT_INSUFF;
			res.ret        = '0;
			res.unreturned = '0;
		end else begin
			res.status     = (change_q == '0) ? ccd_pkg::STAT_EXACT : ccd_pkg::STAT_SHORT;
			res.ret        = ret_q;
			res.unreturned = change_q;
		end
	end

	`ASSERT_CLK(a_ins_cleared,
		(state_q == ccd_pkg::ST_UPD && idx_q == '0) |=> (ins_vld_q == '0),
		"inserted counts not cleared after pay")
	`ASSERT_CLK(a_n_le_stock,
		(state_q == ccd_pkg::ST_UPD) |-> (SW'(n_q) <= SW'(stock_q)),
		"payout exceeds stock")
	`ASSERT_CLK(a_change_falls,
		(state_q == ccd_pkg::ST_UPD) |=> (change_q <= $past(change_q)),
		"change grew during payout")
	`ASSERT_CLK(a_quot_est,
		(state_q == ccd_pkg::ST_NSEL) |-> (rem_w < (TW'(cur_value) << 1)),
		"quotient estimate off by more than one")
	`ASSERT_NEVER(a_short_total,
		state_q == ccd_pkg::ST_DONE && short_q && total_q >= TW'(price_q),
		"insufficient flagged on covered price")

endmodule

### src/coin_change_dispenser.sv
// top level of the coin change dispenser: stream ports, count rams, core, output register
// depends on ccd_pkg, ccd_ram and ccd_core
//
// Keeps stock and inserted coin counts for nine denominations (1 gr up to 5 zl) in two small
// rams. s_tuser carries the command: load stock count, set inserted count or pay. Load and
// insert give no word on the master side; a denomination above 8 or command 3 is dropped.
// A pay reads the inserted counts one per cycle to form the total, then walks the coins
// from 5 zl down with, per denomination: stock read, reciprocal multiply, quotient
// correction and stock limit, write back. A pay that is short of the price skips the walk;
// the next word is taken once the result sits in the output register, which holds it until
// the master side takes it. Stock counts saturate at 2^COUNT_WIDTH-1.
module coin_change_dispenser #(
	parameter int COUNT_WIDTH = ccd_pkg::COUNT_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// denomination[3:0], coin_count[19:4], price[35:20], zero fill
	input  logic [ccd_pkg::IN_TDATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [ccd_pkg::CMD_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status[1:0], ret_1gr .. ret_5zl 16 bits each from bit 2, unreturned[162:146], zero fill
	output logic [ccd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int RES_W = $bits(ccd_pkg::result_t);

	ccd_pkg::mem_ctl_t                 mem_ctl;
	ccd_pkg::result_t                  res;
	logic [COUNT_WIDTH-1:0]            inv_wdata;
	logic [COUNT_WIDTH-1:0]            inv_rdata;
	logic [ccd_pkg::INS_W-1:0]         ins_wdata;
	logic [ccd_pkg::INS_W-1:0]         ins_rdata;
	logic                              res_valid;
	logic                              res_ready;
	logic                              m_tvalid_q;
	logic [ccd_pkg::OUT_TDATA_W-1:0]   m_tdata_q;

	ccd_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.command      (s_tuser),
		.denomination (s_tdata[3:0]),
		.coin_count   (s_tdata[19:4]),
		.price        (s_tdata[35:20]),
		.mem_ctl      (mem_ctl),
		.inv_wdata    (inv_wdata),
		.inv_rdata    (inv_rdata),
		.ins_wdata    (ins_wdata),
		.ins_rdata    (ins_rdata),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	ccd_ram #(
		.DATA_W(COUNT_WIDTH),
		.DEPTH (ccd_pkg::NUM_DENOMS)
	) u_inv_ram (
		.clk   (clk),
		.we    (mem_ctl.inv_we),
		.waddr (mem_ctl.addr),
		.wdata (inv_wdata),
		.re    (mem_ctl.rd_en),
		.raddr (mem_ctl.addr),
		.rdata (inv_rdata)
	);

	ccd_ram #(
		.DATA_W(ccd_pkg::INS_W),
		.DEPTH (ccd_pkg::NUM_DENOMS)
	) u_ins_ram (
		.clk   (clk),
		.we    (mem_ctl.ins_we),
		.waddr (mem_ctl.addr),
		.wdata (ins_wdata),
		.re    (mem_ctl.rd_en),
		.raddr (mem_ctl.addr),
		.rdata (ins_rdata)
	);

	// output word register, refilled as it drains
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= ccd_pkg::OUT_TDATA_W'(RES_W'(res));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### verif/tb_top.sv
// testbench for coin_change_dispenser: directed and random load, insert and pay words
// needs ccd_pkg and the dispenser rtl; payouts are predicted in a scoreboard class
`timescale 1ns / 100ps

localparam logic [ccd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

class change_book;
	logic [ccd_pkg::COUNT_WIDTH-1:0] stock[ccd_pkg::NUM_DENOMS];
	logic [ccd_pkg::INS_W-1:0]       ins[ccd_pkg::NUM_DENOMS];
	int unsigned                     coin_gr[ccd_pkg::NUM_DENOMS];
	ccd_pkg::result_t                payouts_due[$];
	int                              errors;

	function new();
		coin_gr = '{1, 2, 5, 10, 20, 50, 100, 200, 500};
		foreach (stock[i]) begin
			stock[i] = '0;
			ins[i] = '0;
		end
		errors = 0;
	endfunction

	task flag_mismatch(string msg);
		$display("t=%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function int unsigned inserted_total();
		int unsigned sum;
		sum = 0;
		foreach (ins[i])
			sum += ins[i] * coin_gr[i];
		return sum;
	endfunction

	function int due_count();
		return payouts_due.size();
	endfunction

	// apply one accepted word to the shadow stock and queue the payout of a pay
	function void note_word(logic [ccd_pkg::CMD_W-1:0] cmd, logic [ccd_pkg::DENOM_W-1:0] den,
			logic [ccd_pkg::CNT_W-1:0] cnt, logic [ccd_pkg::PRICE_W-1:0] price);
		longint unsigned cmax;
		longint unsigned total;
		longint unsigned change;
		longint unsigned n;
		longint unsigned sum;
		ccd_pkg::result_t pay;
		cmax = (64'd1 << ccd_pkg::COUNT_WIDTH) - 1;
		case (cmd)
			ccd_pkg::CMD_LOAD: begin
				if (den < ccd_pkg::NUM_DENOMS)
					stock[den] = (cnt > cmax) ? cmax[ccd_pkg::COUNT_WIDTH-1:0]
						: ccd_pkg::COUNT_WIDTH'(cnt);
			end
			ccd_pkg::CMD_INSERT: begin
				if (den < ccd_pkg::NUM_DENOMS)
					ins[den] = (cnt > 99) ? ccd_pkg::INS_W'(99) : cnt[ccd_pkg::INS_W-1:0];
			end
			ccd_pkg::CMD_PAY: begin
				pay = '0;
				total = inserted_total();
				if (total < price) begin
					pay.status = ccd_pkg::STAT_INSUFF;
				end else begin
					for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
						sum = stock[i] + ins[i];
						stock[i] = (sum > cmax) ? cmax[ccd_pkg::COUNT_WIDTH-1:0]
							: sum[ccd_pkg::COUNT_WIDTH-1:0];
						ins[i] = '0;
					end
					change = total - price;
					// greedy from the 5 zl coin down, limited by stock and field width
					for (int i = ccd_pkg::NUM_DENOMS - 1; i >= 0; i--) begin
						n = change / coin_gr[i];
						if (n > stock[i])
							n = stock[i];
						if (n > 65535)
							n = 65535;
						stock[i] = stock[i] - n[ccd_pkg::COUNT_WIDTH-1:0];
						change -= n * coin_gr[i];
						pay.ret[i] = n[ccd_pkg::RET_W-1:0];
					end
					pay.status = (change == 0) ? ccd_pkg::STAT_EXACT : ccd_pkg::STAT_SHORT;
					pay.unreturned = change[ccd_pkg::TOTAL_W-1:0];
				end
				payouts_due.push_back(pay);
			end
			default: ;
		endcase
	endfunction

	task check_payout(logic [ccd_pkg::OUT_TDATA_W-1:0] word);
		ccd_pkg::result_t got;
		ccd_pkg::result_t want;
		if (payouts_due.size() == 0) begin
			flag_mismatch($sformatf("payout word with none pending: %h", word));
			return;
		end
		want = payouts_due.pop_front();
		got = ccd_pkg::result_t'(word[$bits(ccd_pkg::result_t)-1:0]);
		if (got.status !== want.status)
			flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++)
			if (got.ret[i] !== want.ret[i])
				flag_mismatch($sformatf("coin %0d returned %0d, want %0d",
					i, got.ret[i], want.ret[i]));
		if (got.unreturned !== want.unreturned)
			flag_mismatch($sformatf("unreturned %0d, want %0d",
				got.unreturned, want.unreturned));
	endtask
endclass

module tb_top;
	localparam int LIMIT = 600000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ccd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [ccd_pkg::CMD_W-1:0]       s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ccd_pkg::OUT_TDATA_W-1:0] m_tdata;

	change_book book = new();
	int                     cycles = 0;
	int                     burst_left = 0;
	int                     items_sent = 0;
	int                     rx_left = 0;

	coin_change_dispenser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: runs of ready and stalls of random length
	always @(posedge clk) begin
		if (rx_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				rx_left = $urandom_range(1, 40);
			end else begin
				m_tready <= 1'b0;
				rx_left = $urandom_range(1, 25);
			end
		end else begin
			rx_left--;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			book.check_payout(m_tdata);

	task automatic send_word(logic [ccd_pkg::CMD_W-1:0] cmd,
			logic [ccd_pkg::DENOM_W-1:0] den, logic [ccd_pkg::CNT_W-1:0] cnt,
			logic [ccd_pkg::PRICE_W-1:0] price);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(15, 40);
				default: gap = $urandom_range(1, 8);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, price, cnt, den};
		do @(posedge clk); while (!s_tready);
		book.note_word(cmd, den, cnt, price);
		burst_left--;
		if (cmd == ccd_pkg::CMD_PAY || (cmd != CMD_UNUSED && den < ccd_pkg::NUM_DENOMS))
			items_sent++;
	endtask

	// hold the sender until every pending payout has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (book.due_count() != 0);
	endtask

	task automatic run_sale();
		int unsigned total;
		int unsigned span;
		int r;
		logic [ccd_pkg::CNT_W-1:0] cnt;
		logic [ccd_pkg::DENOM_W-1:0] den;
		logic [ccd_pkg::PRICE_W-1:0] price;
		repeat ($urandom_range(0, 3)) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				cnt = ccd_pkg::CNT_W'($urandom_range(0, 20));
			else if (r < 8)
				cnt = ccd_pkg::CNT_W'($urandom_range(0, 300));
			else if (r < 9)
				cnt = 16'hFFFF;
			else
				cnt = 16'($urandom);
			send_word(ccd_pkg::CMD_LOAD, ccd_pkg::DENOM_W'($urandom_range(0, 8)), cnt,
				16'($urandom));
		end
		repeat ($urandom_range(1, 5)) begin
			r = $urandom_range(0, 14);
			if (r == 0)
				cnt = 16'($urandom);
			else if (r < 3)
				cnt = ccd_pkg::CNT_W'($urandom_range(0, 99));
			else
				cnt = ccd_pkg::CNT_W'($urandom_range(0, 30));
			den = ($urandom_range(0, 19) == 0) ? ccd_pkg::DENOM_W'($urandom_range(9, 15))
				: ccd_pkg::DENOM_W'($urandom_range(0, 8));
			send_word(ccd_pkg::CMD_INSERT, den, cnt, 16'($urandom));
		end
		total = book.inserted_total();
		r = $urandom_range(0, 99);
		if (r < 40) begin
			span = (total < 600) ? total : 600;
			price = (total > 65535) ? ccd_pkg::PRICE_W'($urandom)
				: ccd_pkg::PRICE_W'(total - $urandom_range(0, span));
		end else if (r < 55) begin
			price = (total > 65535) ? 16'hFFFF : ccd_pkg::PRICE_W'(total);
		end else if (r < 70) begin
			span = (total >= 65535) ? 0 : 65535 - total;
			price = (span == 0) ? 16'hFFFF
				: ccd_pkg::PRICE_W'(total + $urandom_range(1, (span < 500) ? span : 500));
		end else if (r < 80) begin
			price = '0;
		end else begin
			price = 16'($urandom);
		end
		send_word(ccd_pkg::CMD_PAY, ccd_pkg::DENOM_W'($urandom), 16'($urandom), price);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing inserted: zero price pays, nonzero price is insufficient
		send_word(ccd_pkg::CMD_PAY, 0, 0, 0);
		send_word(ccd_pkg::CMD_PAY, 0, 0, 1);
		// empty stock: change cannot be paid
		send_word(ccd_pkg::CMD_INSERT, 8, 1, 0);
		send_word(ccd_pkg::CMD_PAY, 0, 0, 3);
		// dropped words
		send_word(ccd_pkg::CMD_LOAD, 15, 16'hFFFF, 0);
		send_word(ccd_pkg::CMD_LOAD, 9, 16'h5A5A, 0);
		send_word(ccd_pkg::CMD_INSERT, 12, 50, 0);
		send_word(CMD_UNUSED, 0, 16'hFFFF, 16'hFFFF);
		// insert counts clamp at 99
		send_word(ccd_pkg::CMD_INSERT, 0, 16'hFFFF, 0);
		send_word(ccd_pkg::CMD_INSERT, 8, 100, 0);
		send_word(ccd_pkg::CMD_PAY, 0, 0, 16'hFFFF);
		for (int d = 1; d < 8; d++)
			send_word(ccd_pkg::CMD_INSERT, ccd_pkg::DENOM_W'(d), 99, 0);
		send_word(ccd_pkg::CMD_PAY, 0, 0, 16'hFFFF);
		// stock saturates on the way in
		send_word(ccd_pkg::CMD_LOAD, 8, 16'hFFFF, 0);
		send_word(ccd_pkg::CMD_INSERT, 8, 99, 0);
		send_word(ccd_pkg::CMD_PAY, 0, 0, 0);
		send_word(ccd_pkg::CMD_LOAD, 3, 0, 0);
		send_word(ccd_pkg::CMD_PAY, 4'hF, 16'hFFFF, 0);
		drain();

		items_sent = 0;
		while (items_sent < 700) begin
			if ($urandom_range(0, 99) < 75) begin
				run_sale();
			end else begin
				repeat ($urandom_range(1, 3))
					send_word(ccd_pkg::CMD_W'($urandom), ccd_pkg::DENOM_W'($urandom),
						16'($urandom), 16'($urandom));
			end
			if ($urandom_range(0, 60) == 0)
				drain();
		end

		s_tvalid <= 1'b0;
		while (book.due_count() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (book.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
